// File: hdl/bvm_pkg.sv
package bvm_pkg;

   localparam int MASK_BITS     = 32;
   localparam int SYMBOL_COUNT  = 4;
   localparam int SYMBOL_BITS   = 3;
   localparam int POSITION_BITS = 32;
   localparam int WIDTH_BITS    = 6;
   localparam int LENGTH_BITS   = 6;
   localparam int THRESH_BITS   = 5;
   localparam int SCORE_BITS    = 6;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_MASK_SYMBOL_0   = 3'd0,
      CSR_MASK_SYMBOL_1   = 3'd1,
      CSR_MASK_SYMBOL_2   = 3'd2,
      CSR_MASK_SYMBOL_3   = 3'd3,
      CSR_PATTERN_LENGTH  = 3'd4,
      CSR_ERROR_THRESHOLD = 3'd5
   } csr_index_type;

   // per-beat control shared by the cell row and the score unit
   typedef struct packed {
      logic advance;
      logic clear;
      logic separator;
   } step_ctl_type;

   typedef struct packed {
      logic                     hit;
      logic [POSITION_BITS-1:0] hit_position;
      logic [WIDTH_BITS-1:0]    hit_width;
      logic [SCORE_BITS-1:0]    distance;
   } rsp_payload_type;

endpackage

// File: hdl/bvm_if.sv
interface bvm_req_if import bvm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     first_in_region;
   logic                     is_separator;
   logic [SYMBOL_BITS-1:0]   symbol;
   logic [POSITION_BITS-1:0] text_position;
   logic [WIDTH_BITS-1:0]    region_width;

   modport source (output valid, first_in_region, is_separator, symbol, text_position,
                   region_width, input ready);
   modport sink (input valid, first_in_region, is_separator, symbol, text_position,
                 region_width, output ready);
endinterface

interface bvm_rsp_if import bvm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     hit;
   logic [POSITION_BITS-1:0] hit_position;
   logic [WIDTH_BITS-1:0]    hit_width;
   logic [SCORE_BITS-1:0]    distance;

   modport source (output valid, hit, hit_position, hit_width, distance, input ready);
   modport sink (input valid, hit, hit_position, hit_width, distance, output ready);
endinterface

interface bvm_csr_if import bvm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CSR_ADDR_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/bvm_cell.sv
module bvm_cell import bvm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  step_ctl_type ctl,
   input  logic         eq_bit,
   input  logic         carry_in,
   input  logic         ph_prev,
   input  logic         mh_prev,
   output logic         carry_out,
   output logic         ph_bit,
   output logic         mh_bit,
   output logic         vp_bit
);

   logic vp_ff, vp_in;
   logic vm_ff, vm_in;
   logic pv, mv, addend, sum, xh, xv;

   // a region start sees the cleared column
   assign pv = ctl.clear ? 1'b1 : vp_ff;
   assign mv = ctl.clear ? 1'b0 : vm_ff;

   // one bit of (eq & pv) + pv
   assign addend    = eq_bit & pv;
   assign sum       = addend ^ pv ^ carry_in;
   assign carry_out = (addend & pv) | (carry_in & (addend ^ pv));

   assign xh     = (sum ^ pv) | eq_bit;
   assign xv     = eq_bit | mv;
   assign ph_bit = mv | ~(xh | pv);
   assign mh_bit = pv & xh;

   always_comb begin
      vp_in = vp_ff;
      vm_in = vm_ff;
      if (ctl.advance) begin
         if (ctl.separator) begin
            vp_in = 1'b1;
            vm_in = 1'b0;
         end else begin
            vp_in = mh_prev | ~(xv | ph_prev);
            vm_in = ph_prev & xv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b1;
         vm_ff <= 1'b0;
      end else begin
         vp_ff <= vp_in;
         vm_ff <= vm_in;
      end
   end

   assign vp_bit = vp_ff;

endmodule

// File: hdl/bvm_score.sv
module bvm_score import bvm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  step_ctl_type           ctl,
   input  logic [SCORE_BITS-1:0]  start_score,
   input  logic [THRESH_BITS-1:0] threshold,
   input  logic                   ph_end,
   input  logic                   mh_end,
   output logic [SCORE_BITS-1:0]  score_next,
   output logic                   hit
);

   logic [SCORE_BITS-1:0] score_ff, score_in;
   logic [SCORE_BITS-1:0] base;

   assign base = ctl.clear ? start_score : score_ff;

   always_comb begin
      score_next = base;
      if (!ctl.separator) begin
         if (ph_end) begin
            if (base != SCORE_MAX) begin
               score_next = base + SCORE_BITS'(1);
            end
         end else if (mh_end) begin
            if (base != '0) begin
               score_next = base - SCORE_BITS'(1);
            end
         end
      end
   end

   assign hit      = !ctl.separator && (score_next <= SCORE_BITS'(threshold));
   assign score_in = ctl.advance ? score_next : score_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         score_ff <= SCORE_BITS'(1);
      end else begin
         score_ff <= score_in;
      end
   end

endmodule

// File: hdl/bit_vector_edit_distance_matcher_top.sv
// Approximate pattern matcher over a backward text scan, one symbol per beat.
// req_chan: one text symbol with region flags, position and region width.
// rsp_chan: exactly one result per request: hit flag, position and width
//   (zero unless hit) and the edit distance after that symbol.
// csr_chan: register writes, always ready; index 0..3 are the symbol match
//   masks, 4 the pattern length, 5 the error threshold, others are dropped.
//   Write registers only while no request is in flight.
// Throughput: one request per cycle while the output buffer has room. Each result
//   is registered in the output buffer, behind any result still waiting. The clock
//   is set by the carry that ripples through the WORD_BITS cells of the delta-vector
//   row, then the score-bit select and the saturating score update.
// A two-entry output buffer lets one more request in while a result waits;
//   req_chan.ready drops only when both entries are full.
// Reset: synchronous; masks clear, pattern length 1, threshold 0, delta
//   vectors to the empty column, score 1, output buffer empty.
module bit_vector_edit_distance_matcher_top import bvm_pkg::*; #(
   parameter int WORD_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   bvm_req_if.sink   req_chan,
   bvm_rsp_if.source rsp_chan,
   bvm_csr_if.sink   csr_chan
);

   localparam int IdxW = $clog2(WORD_BITS);
   localparam int EffW = LENGTH_BITS + 1;

   logic [MASK_BITS-1:0]   mask_ff [SYMBOL_COUNT];
   logic [LENGTH_BITS-1:0] length_ff;
   logic [THRESH_BITS-1:0] thresh_ff;

   // register file
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SYMBOL_COUNT; s++) begin
            mask_ff[s] <= '0;
         end
         length_ff <= LENGTH_BITS'(1);
         thresh_ff <= '0;
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_MASK_SYMBOL_0:   mask_ff[0] <= csr_chan.data;
            CSR_MASK_SYMBOL_1:   mask_ff[1] <= csr_chan.data;
            CSR_MASK_SYMBOL_2:   mask_ff[2] <= csr_chan.data;
            CSR_MASK_SYMBOL_3:   mask_ff[3] <= csr_chan.data;
            CSR_PATTERN_LENGTH:  length_ff <= csr_chan.data[LENGTH_BITS-1:0];
            CSR_ERROR_THRESHOLD: thresh_ff <= csr_chan.data[THRESH_BITS-1:0];
            default: ;
         endcase
      end
   end

   // clamp the pattern length to 1..WORD_BITS
   logic [EffW-1:0] eff_len;
   logic [IdxW-1:0] end_idx;

   always_comb begin
      if (length_ff == '0) begin
         eff_len = EffW'(1);
      end else if (EffW'(length_ff) > EffW'(WORD_BITS)) begin
         eff_len = EffW'(WORD_BITS);
      end else begin
         eff_len = EffW'(length_ff);
      end
   end

   assign end_idx = IdxW'(eff_len - EffW'(1));

   // output buffer
   logic            out_valid_ff, out_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type out_ff, out_in;
   rsp_payload_type skid_ff, skid_in;
   rsp_payload_type result;
   logic            accept, pop;

   assign req_chan.ready = !skid_valid_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign pop            = out_valid_ff && rsp_chan.ready;

   step_ctl_type ctl;

   assign ctl.advance   = accept;
   assign ctl.clear     = req_chan.first_in_region || req_chan.is_separator;
   assign ctl.separator = req_chan.is_separator;

   // match vector of the incoming symbol; wildcard and unused codes match nothing
   logic                 sym_known;
   logic [WORD_BITS-1:0] eq;

   assign sym_known = req_chan.symbol < SYMBOL_BITS'(SYMBOL_COUNT);

   // cell row
   logic [WORD_BITS:0]   carry;
   logic [WORD_BITS-1:0] ph, mh, vp;

   assign carry[0] = 1'b0;

   for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
      if (i < MASK_BITS) begin : g_eq
         assign eq[i] = sym_known && mask_ff[req_chan.symbol[1:0]][i];
      end else begin : g_eq_zero
         assign eq[i] = 1'b0;
      end

      logic ph_prev, mh_prev;

      if (i == 0) begin : g_head
         assign ph_prev = 1'b0;
         assign mh_prev = 1'b0;
      end else begin : g_link
         assign ph_prev = ph[i-1];
         assign mh_prev = mh[i-1];
      end

      bvm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .eq_bit    (eq[i]),
         .carry_in  (carry[i]),
         .ph_prev   (ph_prev),
         .mh_prev   (mh_prev),
         .carry_out (carry[i+1]),
         .ph_bit    (ph[i]),
         .mh_bit    (mh[i]),
         .vp_bit    (vp[i])
      );
   end

   logic [SCORE_BITS-1:0] score_next;
   logic                  score_hit;

   bvm_score u_score (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .start_score (eff_len[SCORE_BITS-1:0]),
      .threshold   (thresh_ff),
      .ph_end      (ph[end_idx]),
      .mh_end      (mh[end_idx]),
      .score_next  (score_next),
      .hit         (score_hit)
   );

   assign result.hit          = score_hit;
   assign result.hit_position = score_hit ? req_chan.text_position : '0;
   assign result.hit_width    = score_hit ? req_chan.region_width : '0;
   assign result.distance     = score_next;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            // hold the new beat behind the stalled one
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.hit          = out_ff.hit;
   assign rsp_chan.hit_position = out_ff.hit_position;
   assign rsp_chan.hit_width    = out_ff.hit_width;
   assign rsp_chan.distance     = out_ff.distance;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_miss_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.hit |-> rsp_chan.hit_position == '0 &&
      rsp_chan.hit_width == '0)
      else $error("non-hit result carries position or width");

   a_separator_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.is_separator |=> vp == '1)
      else $error("separator did not clear the plus vector");

endmodule

// File: dv/distance_checker.sv
module distance_checker import bvm_pkg::*; #(
   parameter int WORD_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   bvm_req_if   req_mon,
   bvm_rsp_if   rsp_mon,
   bvm_csr_if   csr_mon,
   output int   mismatch_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [MASK_BITS-1:0]   match_mask [SYMBOL_COUNT];
   logic [LENGTH_BITS-1:0] length_reg;
   logic [THRESH_BITS-1:0] threshold_reg;
   logic [WORD_BITS-1:0]   delta_plus;
   logic [WORD_BITS-1:0]   delta_minus;
   logic [SCORE_BITS-1:0]  score;
   rsp_payload_type        expected_results [$];

   // zero acts as one, anything beyond the word acts as the full word
   function automatic int used_length();
      if (length_reg == 0) return 1;
      if (length_reg > WORD_BITS) return WORD_BITS;
      return int'(length_reg);
   endfunction

   function automatic void clear_column();
      delta_plus  = '1;
      delta_minus = '0;
      score       = SCORE_BITS'(used_length());
   endfunction

   function automatic rsp_payload_type scan_symbol(
      input logic                     first,
      input logic                     separator,
      input logic [SYMBOL_BITS-1:0]   symbol,
      input logic [POSITION_BITS-1:0] position,
      input logic [WIDTH_BITS-1:0]    width
   );
      logic [WORD_BITS-1:0] eq;
      logic [WORD_BITS-1:0] xv;
      logic [WORD_BITS-1:0] xh;
      logic [WORD_BITS-1:0] ph;
      logic [WORD_BITS-1:0] mh;
      int                   score_bit;
      rsp_payload_type      result;
      result = '0;
      if (first || separator) clear_column();
      if (!separator) begin
         // wildcard and unused codes match nothing
         eq = (symbol < SYMBOL_COUNT) ? WORD_BITS'(match_mask[symbol[1:0]]) : '0;
         xv = eq | delta_minus;
         xh = (((eq & delta_plus) + delta_plus) ^ delta_plus) | eq;
         ph = delta_minus | ~(xh | delta_plus);
         mh = delta_plus & xh;
         score_bit = used_length() - 1;
         if (ph[score_bit]) begin
            if (score != SCORE_MAX) score++;
         end else if (mh[score_bit]) begin
            if (score != '0) score--;
         end
         ph = ph << 1;
         delta_plus  = (mh << 1) | ~(xv | ph);
         delta_minus = ph & xv;
         if (score <= SCORE_BITS'(threshold_reg)) begin
            result.hit          = 1'b1;
            result.hit_position = position;
            result.hit_width    = width;
         end
      end
      result.distance = score;
      return result;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_payload_type oldest;
      if (reset) begin
         foreach (match_mask[s]) match_mask[s] = '0;
         length_reg    = LENGTH_BITS'(1);
         threshold_reg = '0;
         clear_column();
         expected_results.delete();
         mismatch_count = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_MASK_SYMBOL_0, CSR_MASK_SYMBOL_1, CSR_MASK_SYMBOL_2, CSR_MASK_SYMBOL_3:
                  match_mask[csr_mon.index[1:0]] = csr_mon.data;
               CSR_PATTERN_LENGTH:  length_reg    = csr_mon.data[LENGTH_BITS-1:0];
               CSR_ERROR_THRESHOLD: threshold_reg = csr_mon.data[THRESH_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: result beat with nothing expected, got hit %0b distance %0d",
                        $time, rsp_mon.hit, rsp_mon.distance);
            end else begin
               oldest = expected_results.pop_front();
               check_field("hit", 32'(oldest.hit), 32'(rsp_mon.hit));
               check_field("hit_position", oldest.hit_position, rsp_mon.hit_position);
               check_field("hit_width", 32'(oldest.hit_width), 32'(rsp_mon.hit_width));
               check_field("distance", 32'(oldest.distance), 32'(rsp_mon.distance));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_results.push_back(scan_symbol(req_mon.first_in_region,
                                                   req_mon.is_separator, req_mon.symbol,
                                                   req_mon.text_position,
                                                   req_mon.region_width));
         end
      end
      pending_count = expected_results.size();
   end

endmodule

// File: dv/testbench.sv
module testbench import bvm_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES    = 8;
   localparam int RANDOM_ITEMS    = 1250;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int STUCK_LIMIT     = 4000;
   localparam int DRAIN_CYCLES    = 4;

   localparam logic [SYMBOL_BITS-1:0]   SYMBOL_WILDCARD = 3'd4;
   localparam logic [SYMBOL_BITS-1:0]   SYMBOL_CODE_MAX = 3'd7;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE_LOW   = 3'd6;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE_HIGH  = 3'd7;

   logic clock = 1'b0;
   logic reset;

   int mismatch_total;
   int pending_results;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_off_asked;
   int hold_off_served;
   int hold_off_left;
   int stuck_cycles;

   bvm_req_if req_chan ();
   bvm_rsp_if rsp_chan ();
   bvm_csr_if csr_chan ();

   bit_vector_edit_distance_matcher_top #(.WORD_BITS(32)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   distance_checker #(.WORD_BITS(32)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_mon        (csr_chan),
      .mismatch_count (mismatch_total),
      .pending_count  (pending_results)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side: random stalls, or a long hold-off when one is asked for
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_off_left--;
      end else if (hold_off_served != hold_off_asked) begin
         hold_off_served++;
         hold_off_left = HOLD_OFF_CYCLES - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("[bit_vector_edit_distance_matcher_top] ERROR");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // leaves valid high after the beat so back-to-back beats need no toggle
   task automatic send_symbol(input logic first, input logic separator,
                              input logic [SYMBOL_BITS-1:0] symbol,
                              input logic [POSITION_BITS-1:0] position,
                              input logic [WIDTH_BITS-1:0] width);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.first_in_region <= first;
      req_chan.is_separator    <= separator;
      req_chan.symbol          <= symbol;
      req_chan.text_position   <= position;
      req_chan.region_width    <= width;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_masks(input logic [SYMBOL_COUNT-1:0][MASK_BITS-1:0] masks);
      for (int s = 0; s < SYMBOL_COUNT; s++) begin
         write_reg(CSR_ADDR_BITS'(CSR_MASK_SYMBOL_0 + s), masks[s]);
      end
   endtask

   // drop valid and hold until every result is back
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
   endtask

   initial begin
      logic [SYMBOL_COUNT-1:0][MASK_BITS-1:0] masks;
      logic [1:0]               pattern_rev [32];
      logic [LENGTH_BITS-1:0]   length_value;
      logic [THRESH_BITS-1:0]   threshold_value;
      logic [CSR_DATA_BITS-1:0] data;
      logic [POSITION_BITS-1:0] position;
      logic [WIDTH_BITS-1:0]    width;
      logic [SYMBOL_BITS-1:0]   symbol;
      logic                     first;
      logic                     separator;
      logic                     new_region;
      int                       used_len;
      int                       phase;
      int                       sent;
      int                       region_left;
      int                       plant_idx;

      reset                    = 1'b1;
      req_chan.valid           = 1'b0;
      req_chan.first_in_region = 1'b0;
      req_chan.is_separator    = 1'b0;
      req_chan.symbol          = '0;
      req_chan.text_position   = '0;
      req_chan.region_width    = '0;
      rsp_chan.ready           = 1'b0;
      csr_chan.valid           = 1'b0;
      csr_chan.index           = '0;
      csr_chan.data            = '0;
      send_idle_pct            = 10;
      recv_idle_pct            = 72;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // out of reset all masks are clear, so nothing matches
      send_symbol(1'b1, 1'b0, 3'd0, '0, 6'd1);
      send_symbol(1'b0, 1'b0, SYMBOL_CODE_MAX, '1, 6'd63);
      settle();

      write_masks({32'h8, 32'h4, 32'h2, 32'h1});
      write_reg(CSR_PATTERN_LENGTH, 32'd4);
      write_reg(CSR_ERROR_THRESHOLD, 32'd1);
      csr_chan.valid <= 1'b0;
      send_symbol(1'b1, 1'b0, 3'd0, 32'd100, 6'd5);
      send_symbol(1'b0, 1'b0, 3'd1, 32'd99, 6'd5);
      send_symbol(1'b0, 1'b0, 3'd2, 32'd98, 6'd5);
      send_symbol(1'b0, 1'b0, 3'd3, 32'd97, 6'd5);
      send_symbol(1'b0, 1'b0, SYMBOL_WILDCARD, 32'd96, 6'd5);
      for (int code = SYMBOL_WILDCARD + 1; code <= SYMBOL_CODE_MAX; code++) begin
         send_symbol(1'b0, 1'b0, SYMBOL_BITS'(code), 32'd95 - code, 6'd5);
      end
      // separator on the first beat of a region, then on its own
      send_symbol(1'b1, 1'b1, 3'd0, 32'd90, 6'd42);
      send_symbol(1'b0, 1'b1, 3'd3, 32'd89, 6'd42);
      send_symbol(1'b0, 1'b0, 3'd2, 32'd88, 6'd42);
      settle();

      // all-ones everywhere: length field reads 63 and clamps to the word
      write_masks({SYMBOL_COUNT{32'hFFFF_FFFF}});
      write_reg(CSR_PATTERN_LENGTH, '1);
      write_reg(CSR_ERROR_THRESHOLD, '1);
      write_reg(CSR_SPARE_LOW, '0);
      write_reg(CSR_SPARE_HIGH, '0);
      csr_chan.valid <= 1'b0;
      send_symbol(1'b1, 1'b0, 3'd0, '1, 6'd63);
      send_symbol(1'b0, 1'b0, 3'd3, 32'hFFFF_FFFE, 6'd63);
      send_symbol(1'b0, 1'b0, SYMBOL_WILDCARD, 32'hFFFF_FFFD, 6'd63);
      settle();

      // zero length inside a running region
      write_reg(CSR_PATTERN_LENGTH, '0);
      write_reg(CSR_ERROR_THRESHOLD, '0);
      csr_chan.valid <= 1'b0;
      send_symbol(1'b0, 1'b0, 3'd1, 32'h5555_5555, 6'd21);
      send_symbol(1'b1, 1'b0, 3'd2, 32'hAAAA_AAAA, 6'd42);
      send_symbol(1'b0, 1'b0, SYMBOL_WILDCARD, 32'hAAAA_AAA9, 6'd42);
      settle();

      write_reg(CSR_PATTERN_LENGTH, 32'd32);
      csr_chan.valid <= 1'b0;
      send_symbol(1'b0, 1'b0, 3'd0, 32'h0000_0001, 6'd1);
      send_symbol(1'b0, 1'b0, 3'd3, 32'h0000_0000, 6'd1);

      sent        = 0;
      phase       = 0;
      region_left = 0;
      plant_idx   = -1;
      while (sent < RANDOM_ITEMS) begin
         settle();
         if (sent < RANDOM_ITEMS / 3) begin
            send_idle_pct = 10;
            recv_idle_pct = 72;
         end else if (sent < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 72;
            recv_idle_pct = 10;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         case ($urandom_range(0, 9))
            0: length_value = 6'd1;
            1: length_value = 6'd32;
            2: length_value = 6'd0;
            3: length_value = LENGTH_BITS'($urandom_range(33, 63));
            default: length_value = LENGTH_BITS'($urandom_range(2, 31));
         endcase
         used_len = (length_value == 0) ? 1 : (length_value > 32) ? 32 : int'(length_value);
         case ($urandom_range(0, 7))
            0: threshold_value = '0;
            1: threshold_value = '1;
            2: threshold_value = THRESH_BITS'($urandom_range(0, 31));
            default: threshold_value = THRESH_BITS'($urandom_range(0, used_len / 4));
         endcase

         // otherwise keep masks and carry the open region across the new length
         new_region = (phase == 0) || ($urandom_range(0, 3) != 0);
         if (new_region) begin
            foreach (pattern_rev[i]) pattern_rev[i] = 2'($urandom_range(0, 3));
            for (int s = 0; s < SYMBOL_COUNT; s++) masks[s] = $urandom;
            // most phases get masks consistent with one pattern, garbage above it
            if ($urandom_range(0, 5) != 0) begin
               for (int s = 0; s < SYMBOL_COUNT; s++) begin
                  for (int i = 0; i < used_len; i++) masks[s][i] = (pattern_rev[i] == s);
               end
            end
            write_masks(masks);
            region_left = 0;
         end
         data = $urandom;
         data[LENGTH_BITS-1:0] = length_value;
         write_reg(CSR_PATTERN_LENGTH, data);
         data = $urandom;
         data[THRESH_BITS-1:0] = threshold_value;
         write_reg(CSR_ERROR_THRESHOLD, data);
         if ($urandom_range(0, 7) == 0) begin
            write_reg($urandom_range(0, 1) ? CSR_SPARE_LOW : CSR_SPARE_HIGH, $urandom);
         end
         csr_chan.valid <= 1'b0;

         if (phase % 5 == 3) hold_off_asked++;

         repeat ($urandom_range(30, 110)) begin
            first = 1'b0;
            if (region_left <= 0) begin
               first       = 1'b1;
               position    = $urandom;
               width       = WIDTH_BITS'($urandom_range(1, 63));
               region_left = $urandom_range(1, 2 * used_len + 8);
               plant_idx   = -1;
            end
            separator = ($urandom_range(0, 29) == 0);
            if (plant_idx < 0 && $urandom_range(0, 3) == 0) plant_idx = 0;
            if (plant_idx >= 0) begin
               // plant the reversed pattern with the odd edit
               case ($urandom_range(0, 19))
                  0: begin
                     symbol = SYMBOL_BITS'($urandom_range(0, 3));
                     plant_idx++;
                  end
                  1: symbol = SYMBOL_BITS'($urandom_range(0, 3));
                  2: begin
                     plant_idx++;
                     symbol = (plant_idx < used_len) ? 3'(pattern_rev[plant_idx])
                                                     : SYMBOL_WILDCARD;
                     plant_idx++;
                  end
                  default: begin
                     symbol = SYMBOL_BITS'(pattern_rev[plant_idx]);
                     plant_idx++;
                  end
               endcase
               if (plant_idx >= used_len) plant_idx = -1;
            end else if ($urandom_range(0, 19) == 0) begin
               symbol = SYMBOL_BITS'($urandom_range(SYMBOL_WILDCARD, SYMBOL_CODE_MAX));
            end else begin
               symbol = SYMBOL_BITS'($urandom_range(0, 3));
            end
            send_symbol(first, separator, symbol, position, width);
            position--;
            region_left--;
            sent++;
         end
         phase++;
      end

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_total == 0) begin
         $display("[bit_vector_edit_distance_matcher_top] OK");
      end else begin
         $display("[bit_vector_edit_distance_matcher_top] ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/bvm_pkg.sv
hdl/bvm_if.sv
hdl/bvm_cell.sv
hdl/bvm_score.sv
hdl/bit_vector_edit_distance_matcher_top.sv
dv/distance_checker.sv
dv/testbench.sv
